[design/motion_activity_block_average_macros.svh]
// Assertion macros used by the motion activity checker
`ifndef MOTION_ACTIVITY_BLOCK_AVERAGE_MACROS_SVH
`define MOTION_ACTIVITY_BLOCK_AVERAGE_MACROS_SVH

// Same-cycle implication, clocked on clk, off during rst
`define MAB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during rst
`define MAB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/mab_pkg.sv]
// Shared types and constants for the motion activity block averager
package mab_pkg;

  localparam int AXIS_W = 16;
  localparam int SUM_W  = 29;
  localparam int GAIN_W = 32;

  localparam int BLOCK_LEN_DEF = 20;
  localparam int FRAC_BITS_DEF = 8;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 32'd2575298;
  localparam logic [SUM_W-1:0]  SUM_MAX    = '1;

  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef logic [SUM_W-1:0]         sum_t;
  typedef logic [GAIN_W-1:0]        gain_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_ACCUM,
    ST_SCALE
  } state_t;

endpackage

[design/mab_if.sv]
// Sample and result channel interfaces
interface mab_in_if;
  import mab_pkg::*;

  logic  valid;
  logic  ready;
  axis_t axis_x;
  axis_t axis_y;
  axis_t axis_z;

  modport source (output valid, output axis_x, output axis_y, output axis_z, input ready);
  modport sink   (input valid, input axis_x, input axis_y, input axis_z, output ready);
endinterface

interface mab_out_if;
  import mab_pkg::*;

  logic valid;
  logic ready;
  sum_t block_sum;
  sum_t activity;

  modport source (output valid, output block_sum, output activity, input ready);
  modport sink   (input valid, input block_sum, input activity, output ready);
endinterface

[design/motion_activity_block_average.sv]
// Motion activity block averager: jerk magnitude, block sum and scaled activity
//
// in_ch carries one three-axis sample per transaction (valid/ready). Each sample
// is differenced against the previous one per axis (16-bit wrap), the squares
// are summed on one shared 16x16 multiplier, one axis at a time, and the Q root
// is taken by a restoring square root, one result bit per cycle.
// in_ch.ready is high only in idle, so a new sample is taken only after the last
// has passed the square, root and accumulate steps (and scale at a block's end).
// Every BLOCK_LEN samples one transaction appears on out_ch: the saturated
// block sum and (sum*gain)>>32, registered and loaded by the scale step.
// out_ch is held until taken; the block keeps taking samples while a result
// waits, and stalls only if a second block ends before the first result is
// taken. gain_we/gain_wdata write the gain; write while idle.
// rst (synchronous) clears history, sum, count and output valid, restores gain.
module motion_activity_block_average #(
  parameter int BLOCK_LEN = mab_pkg::BLOCK_LEN_DEF,
  parameter int FRAC_BITS = mab_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 gain_we,
  input  mab_pkg::gain_t       gain_wdata,
  mab_in_if.sink               in_ch,
  mab_out_if.source            out_ch
);
  import mab_pkg::*;

  localparam int MAG_W  = AXIS_W + FRAC_BITS;
  localparam int RAD_W  = 2 * MAG_W;
  localparam int REM_W  = MAG_W + 2;
  localparam int SQ_W   = 2 * AXIS_W;
  localparam int STEP_W = $clog2(MAG_W);
  localparam int CNT_W  = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
  localparam int EXT_W  = ((MAG_W > SUM_W) ? MAG_W : SUM_W) + 1;
  localparam int PROD_W = SUM_W + GAIN_W;

  state_t state;
  state_t state_next;

  logic [AXIS_W-1:0] prev_x;
  logic [AXIS_W-1:0] prev_y;
  logic [AXIS_W-1:0] prev_z;
  logic [AXIS_W-1:0] diff [3];
  logic [1:0]        axis_idx;
  logic [SQ_W-1:0]   sumsq;
  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [MAG_W-1:0]  root;
  logic [STEP_W-1:0] step;
  sum_t              magnitude_total;
  logic [CNT_W-1:0]  samples_in_block;
  gain_t             gain;
  logic              out_valid;
  sum_t              out_sum;
  sum_t              out_act;

  logic              accept;
  logic              load_out;
  logic              last_axis;
  logic              last_step;
  logic              last_sample;
  logic [AXIS_W-1:0] abs_diff;
  logic [SQ_W-1:0]   square;
  logic [SQ_W-1:0]   sumsq_next;
  logic [REM_W-1:0]  rem_shift;
  logic [REM_W-1:0]  trial;
  logic              take_bit;
  logic [EXT_W-1:0]  total_ext;
  sum_t              total_sat;
  logic [PROD_W-1:0] product;

  assign accept      = in_ch.valid && in_ch.ready;
  assign last_axis   = (axis_idx == 2'd2);
  assign last_step   = (step == STEP_W'(MAG_W - 1));
  assign last_sample = (samples_in_block == CNT_W'(BLOCK_LEN - 1));

  // shared squarer
  assign abs_diff   = diff[axis_idx][AXIS_W-1] ? (~diff[axis_idx] + AXIS_W'(1)) : diff[axis_idx];
  assign square     = SQ_W'(abs_diff) * SQ_W'(abs_diff);
  assign sumsq_next = sumsq + square;

  // restoring root, one bit per cycle
  assign rem_shift = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial     = {root, 2'b01};
  assign take_bit  = (rem_shift >= trial);

  assign total_ext = EXT_W'(magnitude_total) + EXT_W'(root);
  assign total_sat = (total_ext > EXT_W'(SUM_MAX)) ? SUM_MAX : total_ext[SUM_W-1:0];

  assign product = PROD_W'(magnitude_total) * PROD_W'(gain);

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_ch.valid) state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        if (last_axis) state_next = ST_ROOT;
      end
      ST_ROOT: begin
        if (last_step) state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        state_next = last_sample ? ST_SCALE : ST_IDLE;
      end
      ST_SCALE: begin
        if (!out_valid || out_ch.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x           <= '0;
      prev_y           <= '0;
      prev_z           <= '0;
      magnitude_total  <= '0;
      samples_in_block <= '0;
      gain             <= GAIN_RESET;
      out_valid        <= 1'b0;
    end else begin
      if (gain_we) gain <= gain_wdata;

      if (accept) begin
        diff[0]  <= AXIS_W'(in_ch.axis_x) - prev_x;
        diff[1]  <= AXIS_W'(in_ch.axis_y) - prev_y;
        diff[2]  <= AXIS_W'(in_ch.axis_z) - prev_z;
        prev_x   <= AXIS_W'(in_ch.axis_x);
        prev_y   <= AXIS_W'(in_ch.axis_y);
        prev_z   <= AXIS_W'(in_ch.axis_z);
        axis_idx <= 2'd0;
        sumsq    <= '0;
      end

      if (state == ST_SQUARE) begin
        sumsq    <= sumsq_next;
        axis_idx <= axis_idx + 2'd1;
        if (last_axis) begin
          rad  <= RAD_W'(sumsq_next) << (2 * FRAC_BITS);
          rem  <= '0;
          root <= '0;
          step <= '0;
        end
      end

      if (state == ST_ROOT) begin
        rad  <= rad << 2;
        rem  <= take_bit ? (rem_shift - trial) : rem_shift;
        root <= {root[MAG_W-2:0], take_bit};
        step <= step + STEP_W'(1);
      end

      if (state == ST_ACCUM) begin
        magnitude_total <= total_sat;
        if (!last_sample) samples_in_block <= samples_in_block + CNT_W'(1);
      end

      if (load_out) begin
        out_sum          <= magnitude_total;
        out_act          <= product[PROD_W-1:GAIN_W];
        magnitude_total  <= '0;
        samples_in_block <= '0;
        out_valid        <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_ch.ready      = (state == ST_IDLE);
  assign out_ch.valid     = out_valid;
  assign out_ch.block_sum = out_sum;
  assign out_ch.activity  = out_act;

endmodule

[design/mab_checker.sv]
// Port-level checks for the motion activity block averager, bound to the top level
`include "motion_activity_block_average_macros.svh"

module mab_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input mab_pkg::sum_t block_sum,
  input mab_pkg::sum_t activity
);
  import mab_pkg::*;

  `MAB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `MAB_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  `MAB_ASSERT_SAME(a_act_le_sum, out_valid, activity <= block_sum, "activity above block sum")
  `MAB_ASSERT_SAME(a_result_from_work, $rose(out_valid), $past(!in_ready), "result while idle")

endmodule

bind motion_activity_block_average mab_checker u_mab_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .block_sum (out_ch.block_sum),
  .activity  (out_ch.activity)
);

[tb/tb_motion_activity_block_average.sv]
// Self-checking testbench for the motion activity block averager
`timescale 1ns / 100ps

module tb_motion_activity_block_average;
  import mab_pkg::*;

  localparam int BLOCK_LEN = BLOCK_LEN_DEF;
  localparam int FRAC_BITS = FRAC_BITS_DEF;
  localparam int SETTLE_CYCLES = 2 * (16 + FRAC_BITS + 5);
  localparam int HOLD_CYCLES = 3000;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 206;
  localparam int CYCLE_LIMIT = 1000000;

  class activity_scoreboard;
    typedef struct packed {
      sum_t block_sum;
      sum_t activity;
    } block_result_t;

    gain_t         gain;
    axis_t         last_x;
    axis_t         last_y;
    axis_t         last_z;
    sum_t          running_total;
    logic [5:0]    samples;
    block_result_t pending_q[$];
    int            errors;

    function new();
      gain = GAIN_RESET;
      last_x = '0;
      last_y = '0;
      last_z = '0;
      running_total = '0;
      samples = '0;
      errors = 0;
    endfunction

    function void set_gain(gain_t g);
      gain = g;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    // difference wraps to 16 bits before squaring
    function logic [63:0] sq_delta(axis_t cur, axis_t old);
      axis_t d;
      int    v;
      d = cur - old;
      v = int'(d);
      if (v < 0) v = -v;
      return 64'(v) * 64'(v);
    endfunction

    function logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] t;
      r = '0;
      for (int i = 31; i >= 0; i--) begin
        t = r | (64'd1 << i);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    function void note_sample(axis_t x, axis_t y, axis_t z);
      logic [63:0]   energy;
      logic [63:0]   total;
      logic [63:0]   scaled;
      block_result_t r;
      energy = sq_delta(x, last_x) + sq_delta(y, last_y) + sq_delta(z, last_z);
      total = 64'(running_total) + floor_sqrt(energy << (2 * FRAC_BITS));
      if (total > 64'(SUM_MAX)) total = 64'(SUM_MAX);
      last_x = x;
      last_y = y;
      last_z = z;
      if (int'(samples) + 1 >= BLOCK_LEN) begin
        scaled = (total * {32'd0, gain}) >> 32;
        r.block_sum = total[SUM_W-1:0];
        r.activity = scaled[SUM_W-1:0];
        pending_q.push_back(r);
        running_total = '0;
        samples = '0;
      end else begin
        running_total = total[SUM_W-1:0];
        samples = samples + 6'd1;
      end
    endfunction

    function void check_result(sum_t s, sum_t a);
      block_result_t r;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, block_sum %0d activity %0d", $time, s, a);
        errors++;
        return;
      end
      r = pending_q.pop_front();
      if (s !== r.block_sum) begin
        $display("%0t: block_sum expected %0d actual %0d", $time, r.block_sum, s);
        errors++;
      end
      if (a !== r.activity) begin
        $display("%0t: activity expected %0d actual %0d", $time, r.activity, a);
        errors++;
      end
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst;
  logic  gain_we;
  gain_t gain_wdata;

  mab_in_if  in_ch();
  mab_out_if out_ch();

  activity_scoreboard sb = new();

  int    src_idle = 0;
  int    rcv_stall = 0;
  bit    hold_pending = 0;
  int    cycles = 0;
  axis_t sent_x = '0;
  axis_t sent_y = '0;
  axis_t sent_z = '0;

  int dir_x[20] = '{32767, -32768, -32768, 0, 0, 1, -1, 16384, -16384, 32767,
                    -32768, 32767, 0, 255, 21845, -21846, 0, 100, 100, -32768};
  int dir_y[20] = '{-32768, 32767, 32767, -1, -1, 0, 1, -16384, 16384, 32767,
                    -32768, 32767, 0, -256, -21846, 21845, 0, 200, 200, -32768};
  int dir_z[20] = '{0, 0, -32768, 0, 0, -1, 1, 16383, -16385, 32767,
                    -32768, 32767, 0, 128, 21845, -21846, 0, 300, 300, -32768};

  motion_activity_block_average i_dut (
    .clk        (clk),
    .rst        (rst),
    .gain_we    (gain_we),
    .gain_wdata (gain_wdata),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.block_sum, out_ch.activity);
      if (in_ch.valid && in_ch.ready) sb.note_sample(in_ch.axis_x, in_ch.axis_y, in_ch.axis_z);
    end
  end

  // result receiver; a requested hold-off is counted here
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rcv_stall);
      end
    end
  end

  task automatic send_sample(axis_t x, axis_t y, axis_t z);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.axis_x <= x;
    in_ch.axis_y <= y;
    in_ch.axis_z <= z;
    sent_x = x;
    sent_y = y;
    sent_z = z;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // random values, small movements, some large jumps and rail values
  function automatic axis_t next_axis(axis_t prev);
    int pick;
    pick = $urandom_range(99);
    if (pick < 25) return axis_t'($urandom);
    if (pick < 75) return prev + axis_t'($urandom_range(1024) - 512);
    if (pick < 90) return prev + axis_t'($urandom_range(16384) - 8192);
    case ($urandom_range(4))
      0:       return axis_t'(-32768);
      1:       return axis_t'(-1);
      2:       return axis_t'(0);
      3:       return axis_t'(1);
      default: return axis_t'(32767);
    endcase
  endfunction

  task automatic drain_and_settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(gain_t g);
    gain_we <= 1'b1;
    gain_wdata <= g;
    @(posedge clk);
    gain_we <= 1'b0;
    sb.set_gain(g);
  endtask

  initial begin
    gain_t g;
    rst <= 1'b1;
    gain_we <= 1'b0;
    gain_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.axis_x <= '0;
    in_ch.axis_y <= '0;
    in_ch.axis_z <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < 20; i++) begin
      send_sample(axis_t'(dir_x[i]), axis_t'(dir_y[i]), axis_t'(dir_z[i]));
    end
    in_ch.valid <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      drain_and_settle();
      case (p)
        0:       g = '1;
        1:       g = '0;
        3:       g = 32'd1;
        4:       g = 32'h8000_0000;
        6:       g = GAIN_RESET;
        default: g = $urandom;
      endcase
      write_gain(g);
      case (p % 4)
        0:       begin src_idle = 0;  rcv_stall = 0;  end
        1:       begin src_idle = 64; rcv_stall = 0;  end
        2:       begin src_idle = 0;  rcv_stall = 64; end
        default: begin src_idle = 32; rcv_stall = 32; end
      endcase
      if (p == 4) hold_pending = 1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 5 && n == 100) begin
          in_ch.valid <= 1'b0;
          do @(posedge clk); while (sb.pending() != 0);
        end
        send_sample(next_axis(sent_x), next_axis(sent_y), next_axis(sent_z));
      end
      in_ch.valid <= 1'b0;
    end

    drain_and_settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/mab_pkg.sv
design/mab_if.sv
design/motion_activity_block_average.sv
design/mab_checker.sv
tb/tb_motion_activity_block_average.sv
